FILE: design/nqc_pkg.sv
// Shared types and constants for the queen completion counter.
// Holds field widths, sequencer codes and the control store; no dependencies.
`default_nettype none

package nqc_pkg;

	localparam int BOARD_W    = 64;
	localparam int COUNT_W    = 7;
	localparam int ROW_STRIDE = 8;
	localparam logic [COUNT_W-1:0] COUNT_MAX = 7'd127;

	localparam int PC_W = 3;

	// program steps
	localparam logic [PC_W-1:0] PC_IDLE = 3'd0;
	localparam logic [PC_W-1:0] PC_LOAD = 3'd1;
	localparam logic [PC_W-1:0] PC_ZROW = 3'd2;
	localparam logic [PC_W-1:0] PC_EVAL = 3'd3;
	localparam logic [PC_W-1:0] PC_BACK = 3'd4;
	localparam logic [PC_W-1:0] PC_BCHK = 3'd5;
	localparam logic [PC_W-1:0] PC_EMIT = 3'd6;

	// branch conditions
	localparam logic [2:0] COND_NONE     = 3'd0;
	localparam logic [2:0] COND_IN_VALID = 3'd1;
	localparam logic [2:0] COND_LOAD_END = 3'd2;
	localparam logic [2:0] COND_DEAD     = 3'd3;
	localparam logic [2:0] COND_ROW_ZERO = 3'd4;
	localparam logic [2:0] COND_PRESET   = 3'd5;
	localparam logic [2:0] COND_OUT_FREE = 3'd6;

	// when the datapath actions of a step take effect
	localparam logic [1:0] EXEC_ALWAYS  = 2'd0;
	localparam logic [1:0] EXEC_ON_JUMP = 2'd1;
	localparam logic [1:0] EXEC_ON_FALL = 2'd2;

	// row register operations
	localparam logic [1:0] ROW_KEEP = 2'd0;
	localparam logic [1:0] ROW_INC  = 2'd1;
	localparam logic [1:0] ROW_DEC  = 2'd2;
	localparam logic [1:0] ROW_CLR  = 2'd3;

	typedef struct packed {
		logic            in_rdy;
		logic            init;
		logic            absorb;
		logic [1:0]      row_op;
		logic            eval;
		logic            pop;
		logic            emit;
		logic [1:0]      exec;
		logic [2:0]      cond;
		logic [PC_W-1:0] jmp;
		logic [PC_W-1:0] nxt;
	} ucode_t;

	function automatic ucode_t ucode_rom(input logic [PC_W-1:0] pc);
		ucode_t w;
		w = '0;
		unique case (pc)
			PC_IDLE: begin
				w.in_rdy = 1'b1; w.init = 1'b1; w.exec = EXEC_ON_JUMP;
				w.cond = COND_IN_VALID; w.jmp = PC_LOAD; w.nxt = PC_IDLE;
			end
			PC_LOAD: begin
				w.absorb = 1'b1; w.row_op = ROW_INC; w.exec = EXEC_ALWAYS;
				w.cond = COND_LOAD_END; w.jmp = PC_ZROW; w.nxt = PC_LOAD;
			end
			PC_ZROW: begin
				w.row_op = ROW_CLR; w.exec = EXEC_ALWAYS;
				w.cond = COND_NONE; w.jmp = PC_EVAL; w.nxt = PC_EVAL;
			end
			PC_EVAL: begin
				w.eval = 1'b1; w.exec = EXEC_ALWAYS;
				w.cond = COND_DEAD; w.jmp = PC_BACK; w.nxt = PC_EVAL;
			end
			PC_BACK: begin
				w.row_op = ROW_DEC; w.exec = EXEC_ON_FALL;
				w.cond = COND_ROW_ZERO; w.jmp = PC_EMIT; w.nxt = PC_BCHK;
			end
			PC_BCHK: begin
				w.pop = 1'b1; w.exec = EXEC_ON_FALL;
				w.cond = COND_PRESET; w.jmp = PC_BACK; w.nxt = PC_EVAL;
			end
			PC_EMIT: begin
				w.emit = 1'b1; w.exec = EXEC_ON_JUMP;
				w.cond = COND_OUT_FREE; w.jmp = PC_IDLE; w.nxt = PC_EMIT;
			end
			default: begin
				w.cond = COND_NONE; w.jmp = PC_IDLE; w.nxt = PC_IDLE;
			end
		endcase
		return w;
	endfunction

endpackage

`default_nettype wire

FILE: design/nqc_board_if.sv
// Request channel carrying one preset board.
// Depends on nqc_pkg for the board width.
`default_nettype none

interface nqc_board_if import nqc_pkg::*;;
	logic               valid;
	logic               ready;
	logic [BOARD_W-1:0] board;

	modport source (output valid, output board, input ready);
	modport sink   (input valid, input board, output ready);
endinterface

`default_nettype wire

FILE: design/nqc_count_if.sv
// Result channel carrying the completion count of one board.
// Depends on nqc_pkg for the count width.
`default_nettype none

interface nqc_count_if import nqc_pkg::*;;
	logic               valid;
	logic               ready;
	logic [COUNT_W-1:0] placements;

	modport source (output valid, output placements, input ready);
	modport sink   (input valid, input placements, output ready);
endinterface

`default_nettype wire

FILE: design/n_queens_completion_counter_top.sv
// Queen completion counter: microcoded backtracking search over one board.
// Depends on nqc_pkg, nqc_board_if and nqc_count_if.
//
// Usage:
//   boards (sink): one request is a 64-bit preset mask, bit row*8+column set
//   where a queen stands; bits outside the BOARD_SIZE square are ignored.
//   counts (source): one result per request, the number of ways to finish the
//   board with one new queen in every free row, saturating at 127.
//   One board is worked on at a time. A request is taken only while the
//   sequencer sits at its idle step. The presets are loaded first, one row per
//   step. Every visit to a row takes one evaluate step, on entry and again
//   after each return from the row below, and every row stepped back over
//   takes a decrement step, then a restore step. Boards with presets need
//   far fewer steps than an empty board. The sequencer walks the control
//   store one step per cycle.
//   The result sits in an output register: if the receiver stalls, the
//   sequencer waits at its emit step until that register frees up, and once
//   it has handed the count over it takes the next request while the
//   previous result is still waiting.
//   Reset (arst_n low) returns the sequencer to idle, drops the result valid
//   and clears all masks and counters.
`default_nettype none

module n_queens_completion_counter_top import nqc_pkg::*; #(
	parameter int BOARD_SIZE = 8
) (
	input  wire         clk,
	input  wire         arst_n,
	nqc_board_if.sink   boards,
	nqc_count_if.source counts
);

	localparam int N  = BOARD_SIZE;
	localparam int RW = $clog2(N + 1);
	localparam int SW = $clog2(N);
	localparam int DW = 2 * N - 1;

	logic [PC_W-1:0]    pc_q;
	logic [BOARD_W-1:0] board_q;
	logic [RW-1:0]      row_q;
	logic [RW-1:0]      start_q;
	logic [N-1:0]       col_q;
	logic [DW-1:0]      diag_q;
	logic [DW-1:0]      anti_q;
	logic [N-1:0]       preset_q;
	logic [COUNT_W-1:0] count_q;
	logic [SW-1:0]      stk_q [N];
	logic               out_valid_q;
	logic [COUNT_W-1:0] placements_q;

	ucode_t        uw;
	logic          take;
	logic          act;
	logic [N:0]    preset_ext;
	logic          row_end;
	logic          preset_hit;
	logic [N-1:0]  free;
	logic          found;
	logic [SW-1:0] pick;
	logic [SW-1:0] popped;
	logic [SW-1:0] q_col;
	logic [N-1:0]  m_col;
	logic [DW-1:0] m_diag;
	logic [DW-1:0] m_anti;
	logic [N-1:0]  rowbits;
	logic [N-1:0]  ab_col;
	logic [DW-1:0] ab_diag;
	logic [DW-1:0] ab_anti;

	assign uw = ucode_rom(pc_q);

	assign boards.ready      = uw.in_rdy;
	assign counts.valid      = out_valid_q;
	assign counts.placements = placements_q;

	assign preset_ext = {1'b0, preset_q};
	assign row_end    = (row_q == RW'(N));
	assign preset_hit = preset_ext[row_q];
	assign popped     = stk_q[row_q[SW-1:0]];
	assign rowbits    = board_q[N-1:0];

	// free squares of the current row at or right of the resume column
	always_comb begin
		logic [DW-1:0] dsel;
		logic [DW-1:0] asel;
		free = '0;
		for (int c = 0; c < N; c++) begin
			dsel = DW'(1) << (int'(row_q) + N - 1 - c);
			asel = DW'(1) << (int'(row_q) + c);
			free[c] = !col_q[c] && !(|(diag_q & dsel)) && !(|(anti_q & asel))
				&& (c >= int'(start_q));
		end
	end

	always_comb begin
		pick = '0;
		for (int c = N - 1; c >= 0; c--) begin
			if (free[c]) begin
				pick = SW'(c);
			end
		end
	end

	assign found = |free;

	// one queen's column and diagonal bits, for placing or lifting
	assign q_col  = uw.pop ? popped : pick;
	assign m_col  = N'(1) << q_col;
	assign m_diag = DW'(1) << (int'(row_q) + N - 1 - int'(q_col));
	assign m_anti = DW'(1) << (int'(row_q) + int'(q_col));

	// all presets of the row being loaded
	always_comb begin
		ab_col  = '0;
		ab_diag = '0;
		ab_anti = '0;
		for (int c = 0; c < N; c++) begin
			if (rowbits[c]) begin
				ab_col[c] = 1'b1;
				ab_diag   = ab_diag | (DW'(1) << (int'(row_q) + N - 1 - c));
				ab_anti   = ab_anti | (DW'(1) << (int'(row_q) + c));
			end
		end
	end

	always_comb begin
		case (uw.cond)
			COND_NONE:     take = 1'b0;
			COND_IN_VALID: take = boards.valid;
			COND_LOAD_END: take = (row_q == RW'(N - 1));
			COND_DEAD:     take = row_end || (!preset_hit && !found);
			COND_ROW_ZERO: take = (row_q == '0);
			COND_PRESET:   take = preset_hit;
			COND_OUT_FREE: take = !out_valid_q || counts.ready;
			default:       take = 1'b0;
		endcase
	end

	always_comb begin
		case (uw.exec)
			EXEC_ALWAYS:  act = 1'b1;
			EXEC_ON_JUMP: act = take;
			EXEC_ON_FALL: act = !take;
			default:      act = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q        <= PC_IDLE;
			row_q       <= '0;
			start_q     <= '0;
			col_q       <= '0;
			diag_q      <= '0;
			anti_q      <= '0;
			preset_q    <= '0;
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			pc_q <= take ? uw.jmp : uw.nxt;

			if (act && uw.emit) begin
				out_valid_q <= 1'b1;
			end else if (counts.ready) begin
				out_valid_q <= 1'b0;
			end

			if (act) begin
				case (uw.row_op)
					ROW_INC: row_q <= row_q + RW'(1);
					ROW_DEC: row_q <= row_q - RW'(1);
					ROW_CLR: begin
						row_q   <= '0;
						start_q <= '0;
					end
					default: ;
				endcase

				if (uw.init) begin
					row_q    <= '0;
					start_q  <= '0;
					col_q    <= '0;
					diag_q   <= '0;
					anti_q   <= '0;
					preset_q <= '0;
					count_q  <= '0;
				end

				if (uw.absorb) begin
					col_q  <= col_q | ab_col;
					diag_q <= diag_q | ab_diag;
					anti_q <= anti_q | ab_anti;
					preset_q[row_q[SW-1:0]] <= |rowbits;
				end

				if (uw.eval) begin
					if (row_end) begin
						if (count_q != COUNT_MAX) begin
							count_q <= count_q + COUNT_W'(1);
						end
					end else if (preset_hit) begin
						row_q   <= row_q + RW'(1);
						start_q <= '0;
					end else if (found) begin
						col_q   <= col_q | m_col;
						diag_q  <= diag_q | m_diag;
						anti_q  <= anti_q | m_anti;
						row_q   <= row_q + RW'(1);
						start_q <= '0;
					end
				end

				if (uw.pop) begin
					col_q   <= col_q & ~m_col;
					diag_q  <= diag_q & ~m_diag;
					anti_q  <= anti_q & ~m_anti;
					start_q <= RW'(q_col) + RW'(1);
				end
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (act && uw.init) begin
			board_q <= boards.board;
		end else if (act && uw.absorb) begin
			board_q <= board_q >> ROW_STRIDE;
		end
		if (act && uw.eval && !row_end && !preset_hit && found) begin
			stk_q[row_q[SW-1:0]] <= pick;
		end
		if (act && uw.emit) begin
			placements_q <= count_q;
		end
	end

	a_accept_starts_load: assert property (@(posedge clk) disable iff (!arst_n)
		boards.valid && boards.ready |=> pc_q == PC_LOAD && row_q == '0)
		else $error("accepted request did not start the preset load");

	a_eval_row_bound: assert property (@(posedge clk) disable iff (!arst_n)
		pc_q == PC_EVAL |-> row_q <= RW'(N))
		else $error("search row ran past the board");

	a_emit_count: assert property (@(posedge clk) disable iff (!arst_n)
		pc_q == PC_EMIT && take |=> counts.valid && counts.placements == $past(count_q))
		else $error("emitted result does not match the search count");

endmodule

`default_nettype wire
